/* sv/assert_macros.svh */
// Assertion macros used by the checker of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, switched off while reset is held.
`define RRTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define RRTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `RRTS_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `RRTS_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* sv/rrts_pkg.sv */
// Package with the shared types and constants of the round-robin task scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int PRIO_LEVELS = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_LOW    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_MID    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_HIGH   = 8'd3;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_CREATE   = 3'd1,
        CMD_KILL     = 3'd2,
        CMD_BLOCK    = 3'd3,
        CMD_UNBLOCK  = 3'd4,
        CMD_SET_PRIO = 3'd5,
        CMD_YIELD    = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_TERM  = 2'd0,
        ST_READY = 2'd1,
        ST_RUN   = 2'd2,
        ST_BLOCK = 2'd3
    } t_status;

    // Request fields, first field in the highest bits.
    typedef struct packed {
        logic [1:0]  priority_req;
        logic [15:0] task_id;
        t_cmd        command;
    } t_request;

    // Result fields, first field in the highest bits.
    typedef struct packed {
        logic        halted;
        logic [15:0] created_id;
        logic [15:0] running_id;
        logic [3:0]  running_slot;
        logic        idle;
        logic        ok;
    } t_result;

    typedef struct packed {
        logic        id_load;
        logic [15:0] first_id;
        logic [7:0]  q_low;
        logic [7:0]  q_mid;
        logic [7:0]  q_high;
    } t_cfg;

endpackage

/* sv/rrts_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rrts_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read-first: a read of the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/rrts_ctrl.sv */
// Sequencer of the scheduler: walks and updates the task table held in RAM.
`timescale 1ns / 1ps

module rrts_ctrl #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  rrts_pkg::t_request i_req,
    input  rrts_pkg::t_cfg    i_cfg,
    input  logic              i_res_ready,
    output logic              o_res_push,
    output rrts_pkg::t_result o_res
);
    import rrts_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int EW     = ID_BITS + 10;
    localparam logic [SLOT_W:0]    SLOTS_X   = (SLOT_W + 1)'(SLOTS);
    localparam logic [CNT_W-1:0]   SLOTS_C   = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_APPLY, S_RUN, S_FIN, S_RES
    } t_state;

    typedef enum logic [1:0] {SC_ID, SC_TERM, SC_READY} t_scan;

    t_state               r_state, n_state;
    t_scan                r_mode, n_mode;
    t_cmd                 r_cmd, n_cmd;
    logic [15:0]          r_tid, n_tid;
    logic [1:0]           r_prio, n_prio;
    logic [SLOT_W-1:0]    r_cur, n_cur;
    logic [CNT_W-1:0]     r_live, n_live;
    logic [CNT_W-1:0]     r_blocked, n_blocked;
    logic [ID_BITS-1:0]   r_next_id, n_next_id;
    logic [31:0]          r_tick, n_tick;
    logic [31:0]          r_slice, n_slice;
    logic                 r_pend, n_pend;
    logic                 r_halt, n_halt;
    logic                 r_ok, n_ok;
    logic [ID_BITS-1:0]   r_created, n_created;
    logic [SLOTS-1:0]     r_valid, n_valid;
    logic [SLOT_W:0]      r_iss, n_iss;
    logic                 r_ev, n_ev;
    logic [SLOT_W-1:0]    r_base, n_base;
    logic [SLOT_W-1:0]    r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0]    r_hit_idx, n_hit_idx;
    logic [EW-1:0]        r_hit_ent, n_hit_ent;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_wa;
    logic [EW-1:0]        ram_wd;
    logic [SLOT_W-1:0]    ram_ra;
    logic [EW-1:0]        ram_q;

    t_status              rd_st;
    logic [7:0]           rd_qt;
    logic [ID_BITS-1:0]   rd_id;
    t_status              h_st;
    logic [7:0]           h_qt;
    logic [ID_BITS-1:0]   h_id;
    logic [ID_BITS-1:0]   tid_m;
    logic [SLOT_W:0]      scan_sum;
    logic [SLOT_W-1:0]    scan_addr;
    logic                 hit;
    logic [7:0]           sel_quantum;
    logic [31:0]          elapsed;
    logic                 expired;
    logic                 can_search;
    logic [SLOT_W-1:0]    next_base;

    function automatic logic [EW-1:0] pack_ent(input t_status st, input logic [7:0] qt,
                                               input logic [ID_BITS-1:0] id);
        return {st, qt, id};
    endfunction

    function automatic logic [7:0] quantum_of(input logic [1:0] prio, input t_cfg c);
        logic [7:0] q;
        case (prio)
            2'd1:    q = c.q_mid;
            2'd2:    q = c.q_high;
            default: q = c.q_low;
        endcase
        return q;
    endfunction

    rrts_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_q)
    );

    // A slot that was never written reads as terminated.
    assign rd_st = r_valid[r_rd_idx] ? t_status'(ram_q[EW-1 -: 2]) : ST_TERM;
    assign rd_qt = ram_q[ID_BITS +: 8];
    assign rd_id = ram_q[ID_BITS-1:0];
    assign h_st  = t_status'(r_hit_ent[EW-1 -: 2]);
    assign h_qt  = r_hit_ent[ID_BITS +: 8];
    assign h_id  = r_hit_ent[ID_BITS-1:0];
    assign tid_m = ID_BITS'(r_tid);

    assign scan_sum  = {1'b0, r_base} + r_iss;
    assign scan_addr = (scan_sum >= SLOTS_X) ? SLOT_W'(scan_sum - SLOTS_X) : SLOT_W'(scan_sum);
    assign next_base = (r_cur == LAST_SLOT) ? '0 : r_cur + SLOT_W'(1);

    assign sel_quantum = quantum_of(r_prio, i_cfg);
    assign elapsed     = r_tick - r_slice;
    assign expired     = elapsed >= 32'(rd_qt);
    assign can_search  = ({1'b0, r_blocked} + (CNT_W + 1)'(1)) < {1'b0, r_live};

    always_comb begin
        case (r_mode)
            SC_ID:    hit = (rd_st != ST_TERM) && (rd_id == tid_m);
            SC_TERM:  hit = (rd_st == ST_TERM);
            default:  hit = (rd_st == ST_READY);
        endcase
    end

    assign o_req_ready = i_rst_n && (r_state == S_IDLE);

    always_comb begin
        o_res.ok           = r_ok;
        o_res.idle         = (r_live == '0);
        o_res.running_slot = 4'(r_cur);
        o_res.running_id   = (r_live == '0) ? 16'd0 : 16'(rd_id);
        o_res.created_id   = 16'(r_created);
        o_res.halted       = r_halt;
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_cmd     = r_cmd;
        n_tid     = r_tid;
        n_prio    = r_prio;
        n_cur     = r_cur;
        n_live    = r_live;
        n_blocked = r_blocked;
        n_next_id = r_next_id;
        n_tick    = r_tick;
        n_slice   = r_slice;
        n_pend    = r_pend;
        n_halt    = r_halt;
        n_ok      = r_ok;
        n_created = r_created;
        n_valid   = r_valid;
        n_iss     = r_iss;
        n_ev      = r_ev;
        n_base    = r_base;
        n_hit_idx = r_hit_idx;
        n_hit_ent = r_hit_ent;
        ram_we    = 1'b0;
        ram_wa    = r_hit_idx;
        ram_wd    = r_hit_ent;
        ram_ra    = r_cur;
        o_res_push = 1'b0;

        if (i_cfg.id_load) begin
            n_next_id = ID_BITS'(i_cfg.first_id);
        end

        unique case (r_state)
            S_IDLE: begin
                // The current slot is read here so that its entry is ready at dispatch.
                if (i_req_valid && o_req_ready) begin
                    n_cmd     = i_req.command;
                    n_tid     = i_req.task_id;
                    n_prio    = i_req.priority_req;
                    n_ok      = 1'b0;
                    n_created = '0;
                    if (i_req.command == CMD_TICK) begin
                        n_tick = r_tick + 32'd1;
                    end
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FIN;
                n_iss   = '0;
                n_ev    = 1'b0;
                n_base  = '0;
                unique case (r_cmd)
                    CMD_TICK: begin
                        n_ok = 1'b1;
                        if ((r_live != '0) && (r_pend || (!r_halt && expired))) begin
                            n_pend    = 1'b0;
                            n_slice   = r_tick;
                            n_hit_idx = r_cur;
                            if (rd_st == ST_RUN) begin
                                ram_we    = 1'b1;
                                ram_wa    = r_cur;
                                ram_wd    = pack_ent(ST_READY, rd_qt, rd_id);
                                n_hit_ent = pack_ent(ST_READY, rd_qt, rd_id);
                            end else begin
                                n_hit_ent = pack_ent(rd_st, rd_qt, rd_id);
                            end
                            if (can_search || (rd_st != ST_RUN && rd_st != ST_READY)) begin
                                n_mode  = SC_READY;
                                n_base  = next_base;
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                    end
                    CMD_CREATE: begin
                        if (r_live < SLOTS_C) begin
                            n_mode  = SC_TERM;
                            n_state = S_SCAN;
                        end
                    end
                    CMD_KILL, CMD_BLOCK, CMD_UNBLOCK: begin
                        n_mode  = SC_ID;
                        n_state = S_SCAN;
                    end
                    CMD_SET_PRIO: begin
                        if (int'(r_prio) < PRIO_LEVELS) begin
                            n_mode  = SC_ID;
                            n_state = S_SCAN;
                        end
                    end
                    CMD_YIELD: begin
                        n_pend = 1'b1;
                        n_ok   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // One read issued per cycle; its data is examined in the next cycle.
                if (r_iss < SLOTS_X) begin
                    ram_ra = scan_addr;
                    n_iss  = r_iss + (SLOT_W + 1)'(1);
                    n_ev   = 1'b1;
                end else begin
                    n_ev = 1'b0;
                end
                if (r_ev) begin
                    if (hit) begin
                        n_hit_idx = r_rd_idx;
                        n_hit_ent = pack_ent(rd_st, rd_qt, rd_id);
                        if (r_mode == SC_READY) begin
                            n_cur   = r_rd_idx;
                            n_state = S_RUN;
                        end else begin
                            n_state = S_APPLY;
                        end
                    end else if (r_iss == SLOTS_X) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RUN: begin
                ram_we  = 1'b1;
                ram_wa  = r_hit_idx;
                ram_wd  = pack_ent(ST_RUN, h_qt, h_id);
                n_state = S_FIN;
            end
            S_APPLY: begin
                n_state = S_FIN;
                ram_wa  = r_hit_idx;
                unique case (r_cmd)
                    CMD_CREATE: begin
                        ram_we             = 1'b1;
                        ram_wd             = pack_ent(ST_READY, sel_quantum, r_next_id);
                        n_valid[r_hit_idx] = 1'b1;
                        n_live             = r_live + CNT_W'(1);
                        n_created          = r_next_id;
                        n_next_id          = r_next_id + ID_BITS'(1);
                        n_ok               = 1'b1;
                    end
                    CMD_KILL: begin
                        ram_we = 1'b1;
                        ram_wd = pack_ent(ST_TERM, h_qt, h_id);
                        if (h_st == ST_BLOCK) begin
                            n_blocked = r_blocked - CNT_W'(1);
                        end
                        n_live = r_live - CNT_W'(1);
                        n_ok   = 1'b1;
                    end
                    CMD_BLOCK: begin
                        if (h_st != ST_BLOCK) begin
                            ram_we    = 1'b1;
                            ram_wd    = pack_ent(ST_BLOCK, h_qt, h_id);
                            n_blocked = r_blocked + CNT_W'(1);
                            n_ok      = 1'b1;
                            if (r_live == r_blocked + CNT_W'(1)) begin
                                n_halt = 1'b1;
                            end
                        end
                    end
                    CMD_UNBLOCK: begin
                        if (h_st != ST_READY) begin
                            ram_we = 1'b1;
                            ram_wd = pack_ent(ST_READY, h_qt, h_id);
                            if (h_st == ST_BLOCK) begin
                                n_blocked = r_blocked - CNT_W'(1);
                            end
                            n_ok = 1'b1;
                            if (r_halt) begin
                                n_halt = 1'b0;
                                n_pend = 1'b1;
                            end
                        end
                    end
                    CMD_SET_PRIO: begin
                        ram_we = 1'b1;
                        ram_wd = pack_ent(h_st, sel_quantum, h_id);
                        n_ok   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FIN: begin
                n_state = S_RES;
            end
            S_RES: begin
                // Blocking the task in the current slot forces a switch at the next tick.
                if (i_res_ready) begin
                    o_res_push = 1'b1;
                    if (r_cmd == CMD_BLOCK && r_ok && r_live != '0
                            && 32'(r_tid) == 32'(rd_id)) begin
                        n_pend = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_rd_idx = ram_ra;

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_tid     <= n_tid;
        r_prio    <= n_prio;
        r_ok      <= n_ok;
        r_created <= n_created;
        r_iss     <= n_iss;
        r_base    <= n_base;
        r_rd_idx  <= n_rd_idx;
        r_hit_idx <= n_hit_idx;
        r_hit_ent <= n_hit_ent;
        r_mode    <= n_mode;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_live    <= '0;
            r_blocked <= '0;
            r_next_id <= '0;
            r_tick    <= '0;
            r_slice   <= '0;
            r_pend    <= 1'b1;
            r_halt    <= 1'b0;
            r_valid   <= '0;
            r_ev      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_live    <= n_live;
            r_blocked <= n_blocked;
            r_next_id <= n_next_id;
            r_tick    <= n_tick;
            r_slice   <= n_slice;
            r_pend    <= n_pend;
            r_halt    <= n_halt;
            r_valid   <= n_valid;
            r_ev      <= n_ev;
        end
    end

endmodule

/* sv/round_robin_task_scheduler.sv */
// Round-robin task scheduler: one request at a time, task table in a single RAM.
// A request with no table walk (yield, tick without switch) passes only the dispatch,
// finish and result states; one that seeks an id, a free slot or the next ready task
// scans one slot per cycle through the RAM read port. The result is registered.
// Synchronous active-low reset marks every slot free and restores the register defaults
// at once, with no clearing pass.
`timescale 1ns / 1ps

module round_robin_task_scheduler #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], task_id[18:3], priority_req[20:19], zero pad[23:21]
    input  logic [rrts_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok[0], idle[1], running_slot[5:2], running_id[21:6], created_id[37:22],
    // halted[38], zero pad[39]
    output logic [rrts_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [rrts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rrts_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import rrts_pkg::*;

    localparam int REQ_W = $bits(t_request);

    t_request   req;
    t_cfg       cfg;
    t_result    res;
    logic       res_push;
    logic       res_ready;
    logic       cfg_we;
    logic [7:0] r_q_low, r_q_mid, r_q_high;
    logic       r_out_valid;
    t_result    r_out;

    assign req = t_request'(s_axis_tdata[REQ_W-1:0]);

    assign o_cfg_ready = i_rst_n;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_low  <= 8'd1;
            r_q_mid  <= 8'd2;
            r_q_high <= 8'd4;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_Q_LOW:  r_q_low  <= i_cfg_data[7:0];
                CFG_Q_MID:  r_q_mid  <= i_cfg_data[7:0];
                CFG_Q_HIGH: r_q_high <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // The first id is not kept here: its write reloads the id counter directly.
    always_comb begin
        cfg.id_load  = cfg_we && (i_cfg_index == CFG_FIRST_ID);
        cfg.first_id = i_cfg_data;
        cfg.q_low    = r_q_low;
        cfg.q_mid    = r_q_mid;
        cfg.q_high   = r_q_high;
    end

    rrts_ctrl #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .i_cfg       (cfg),
        .i_res_ready (res_ready),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Output register: the sequencer may take the next request while a result waits.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out);

endmodule

/* sv/rrts_checker.sv */
// Port-level checker for the round-robin task scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rrts_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rrts_pkg::*;

    // A stalled result must stay valid and unchanged.
    `RRTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Requests are handled one at a time.
    `RRTS_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

    // With no live task the running id reads as zero.
    `RRTS_ASSERT_IMPL(a_idle_no_id, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[21:6] == 16'd0, "running id set while idle")

    // A non-zero created id only comes with a successful create.
    `RRTS_ASSERT_IMPL(a_created_ok, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[37:22] != 16'd0), m_axis_tdata[0], "created id without success")

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
